// ===== sv/rwa_pkg.sv =====
// Shared constants and types for the running window average block.
package rwa_pkg;

   // Default sizing, handed to the top-level parameters.
   localparam int MAX_WINDOW_DEF    = 64;
   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int FRACTION_BITS_DEF = 8;

   // Window length register: fixed field width and its reset value.
   localparam int               WIN_BITS  = 7;
   localparam logic [WIN_BITS-1:0] WIN_RESET = 7'd64;

   // Main sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

endpackage

// ===== sv/running_window_average.sv =====
// Top level of the running window average: ring control, running sum and result stage.
//
// Usage:
//  - Request channel (req_valid / req_stall / req_sample) carries one signed sample.
//    A request is taken at a rising edge with req_valid high and req_stall low.
//  - Response channel (rsp_valid / rsp_stall / rsp_average) returns exactly one
//    average per request: the mean of the last window_len samples (fewer while the
//    window fills), signed fixed point with FRACTION_BITS fraction bits, truncated
//    toward zero.
//  - csr_write_enable / csr_window_len load the window length and restart the window
//    (pointer, fill count and sum go to zero). A length of zero acts as one, a length
//    above MAX_WINDOW acts as MAX_WINDOW. Write only while the block is idle.
//  - One request is in flight at a time: a new request is taken only after the previous
//    result has gone through the bit-serial divider and into the output register.
//  - The result waits in an output register: if rsp_stall holds it, the next request
//    is still taken and processed, and only the hand-over of its result waits.
//  - Synchronous reset clears the control state and loads window length 64. The
//    sample ring needs no clearing: an entry is read only after it was written.
module running_window_average #(
   parameter int MAX_WINDOW    = rwa_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS   = rwa_pkg::SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = rwa_pkg::FRACTION_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_stall,
   input  logic signed [SAMPLE_BITS-1:0]                req_sample,
   output logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0]  rsp_average,
   input  logic                                         csr_write_enable,
   input  logic [rwa_pkg::WIN_BITS-1:0]                 csr_window_len
);

   import rwa_pkg::*;

   localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
   localparam int PTR_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int OUT_BITS = SAMPLE_BITS + FRACTION_BITS;
   localparam int LEN_BITS = (WIN_BITS > CNT_BITS) ? WIN_BITS : CNT_BITS;

   // Sequencer and window state.
   state_type                   state_ff, state_in;
   logic [WIN_BITS-1:0]         window_len_ff, window_len_in;
   logic [PTR_BITS-1:0]         ptr_ff, ptr_in;
   logic [CNT_BITS-1:0]         fill_ff, fill_in;
   logic signed [SUM_BITS-1:0]  sum_ff, sum_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_BITS-1:0]  rsp_average_ff, rsp_average_in;

   // Datapath nets.
   logic [LEN_BITS-1:0]         win_ext;
   logic [CNT_BITS-1:0]         eff_len;
   logic [PTR_BITS-1:0]         ptr_use;
   logic [CNT_BITS-1:0]         ptr_next;
   logic                        full;
   logic [SAMPLE_BITS-1:0]      ram_rd_data;
   logic signed [SAMPLE_BITS-1:0] old_sample;
   logic                        out_free;

   // Sequencer outputs.
   logic                        req_accept;
   logic                        ram_rd_en;
   logic                        update;
   logic                        rsp_load;

   // Divider.
   logic                        div_done;
   logic signed [OUT_BITS-1:0]  div_quotient;

   // Effective window: clamp zero to one and anything past the ring to its depth.
   always_comb begin
      win_ext = LEN_BITS'(window_len_ff);
      if (win_ext == '0) begin
         eff_len = CNT_BITS'(1);
      end else if (win_ext > LEN_BITS'(MAX_WINDOW)) begin
         eff_len = CNT_BITS'(MAX_WINDOW);
      end else begin
         eff_len = CNT_BITS'(win_ext);
      end
   end

   // Slot to overwrite; the oldest sample sits there once the window is full.
   assign ptr_use    = (CNT_BITS'(ptr_ff) >= eff_len) ? '0 : ptr_ff;
   assign ptr_next   = CNT_BITS'(ptr_use) + CNT_BITS'(1);
   assign full       = fill_ff >= eff_len;
   assign old_sample = signed'(ram_rd_data);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_accept = req_valid && !req_stall;

   rwa_ram #(
      .WIDTH     (SAMPLE_BITS),
      .DEPTH     (MAX_WINDOW),
      .ADDR_BITS (PTR_BITS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (update),
      .wr_addr (ptr_use),
      .wr_data (sample_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ptr_use),
      .rd_data (ram_rd_data)
   );

   rwa_divider #(
      .SUM_BITS      (SUM_BITS),
      .CNT_BITS      (CNT_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .OUT_BITS      (OUT_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (update),
      .dividend (sum_in),
      .divisor  (fill_in),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall = 1'b1;
      ram_rd_en = 1'b0;
      update    = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // Fetch the oldest slot together with the request.
            req_stall = 1'b0;
            ram_rd_en = req_valid;
         end
         ST_UPDATE: begin
            update = 1'b1;
         end
         ST_DIVIDE: begin
            rsp_load = div_done && out_free;
         end
         ST_HOLD: begin
            rsp_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Window and result registers.
   always_comb begin
      window_len_in  = window_len_ff;
      ptr_in         = ptr_ff;
      fill_in        = fill_ff;
      sum_in         = sum_ff;
      sample_in      = req_accept ? req_sample : sample_ff;
      rsp_average_in = rsp_load ? div_quotient : rsp_average_ff;
      rsp_valid_in   = rsp_load || (rsp_valid_ff && rsp_stall);

      if (csr_write_enable) begin
         // Restart the window.
         window_len_in = csr_window_len;
         ptr_in        = '0;
         fill_in       = '0;
         sum_in        = '0;
      end else if (update) begin
         // Drop the oldest sample once full, add the new one, advance.
         sum_in  = sum_ff - (full ? SUM_BITS'(old_sample) : SUM_BITS'(0))
                   + SUM_BITS'(sample_ff);
         fill_in = full ? fill_ff : fill_ff + CNT_BITS'(1);
         ptr_in  = (ptr_next >= eff_len) ? '0 : PTR_BITS'(ptr_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_len_ff <= WIN_RESET;
         ptr_ff        <= '0;
         fill_ff       <= '0;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_len_ff <= window_len_in;
         ptr_ff        <= ptr_in;
         fill_ff       <= fill_in;
         sum_ff        <= sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sample_ff      <= sample_in;
      rsp_average_ff <= rsp_average_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

   // The fill count never passes the effective window.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= eff_len)
      else $error("fill count exceeds window length");

   // The write pointer stays inside the effective window.
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_BITS'(ptr_ff) < eff_len)
      else $error("write pointer outside window");

   // An accepted request moves straight to the sum update.
   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_UPDATE)
      else $error("accepted request did not reach update");

   // The divider finishes only while the sequencer waits for it.
   a_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside divide state");

endmodule

// ===== sv/rwa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rwa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rwa_divider.sv =====
// Iterative restoring divider: signed sum scaled by the fraction bits over the fill count.
module rwa_divider #(
   parameter int SUM_BITS      = 22,
   parameter int CNT_BITS      = 7,
   parameter int FRACTION_BITS = 8,
   parameter int OUT_BITS      = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SUM_BITS-1:0] dividend,
   input  logic [CNT_BITS-1:0]        divisor,
   output logic                       done,
   output logic signed [OUT_BITS-1:0] quotient
);

   localparam int DIV_BITS  = SUM_BITS + FRACTION_BITS;
   localparam int STEP_BITS = $clog2(DIV_BITS + 1);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DIV_BITS - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [DIV_BITS-1:0]  quo_ff, quo_in;
   logic [CNT_BITS-1:0]  rem_ff, rem_in;
   logic [CNT_BITS-1:0]  den_ff, den_in;

   logic [SUM_BITS-1:0]  magnitude;
   logic [CNT_BITS:0]    trial;
   logic                 fits;
   logic [DIV_BITS-1:0]  signed_quo;

   always_comb begin
      magnitude = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
      trial     = {rem_ff, quo_ff[DIV_BITS-1]};
      fits      = trial >= {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;

      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[SUM_BITS-1];
         step_in = '0;
         quo_in  = DIV_BITS'(magnitude) << FRACTION_BITS;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         // One quotient bit per cycle, MSB first.
         rem_in  = fits ? CNT_BITS'(trial - {1'b0, den_ff}) : CNT_BITS'(trial);
         quo_in  = {quo_ff[DIV_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   // Restore the sign; truncation toward zero falls out of dividing magnitudes.
   assign signed_quo = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient   = signed'(signed_quo[OUT_BITS-1:0]);
   assign done       = done_ff;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the running window average block.
`timescale 1ns / 1ps

module tb;
   import rwa_pkg::*;

   localparam int SMP_W         = SAMPLE_BITS_DEF;
   localparam int AVG_W         = SAMPLE_BITS_DEF + FRACTION_BITS_DEF;
   localparam int WIN_MAX       = MAX_WINDOW_DEF;
   // Settling time waited after the queues drain, with margin over the response latency.
   localparam int SETTLE_CYCLES = 40;
   localparam int IDLE_PCT      = 37;
   localparam int HOLD_AT       = 300;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASES        = 12;
   localparam int BATCHES       = 4;
   localparam int BATCH_LEN     = 29;

   // Flavors of random sample content within one batch.
   typedef enum int {
      MIX_FULL,
      MIX_RAILS,
      MIX_NEAR_ZERO,
      MIX_CONSTANT
   } sample_mix_type;

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic                    req_stall;
   logic signed [SMP_W-1:0] req_sample       = '0;
   logic                    rsp_valid;
   logic                    rsp_stall        = 1'b0;
   logic signed [AVG_W-1:0] rsp_average;
   logic                    csr_write_enable = 1'b0;
   logic [WIN_BITS-1:0]     csr_window_len   = '0;

   // Requests still to be offered, and the averages the block owes us, oldest first.
   logic signed [SMP_W-1:0] sample_queue[$];
   logic [AVG_W-1:0]        mean_expect[$];
   logic [AVG_W-1:0]        front_mean;

   // Shadow copy of the window state, kept in step with accepted requests.
   logic signed [SMP_W-1:0] ring_hist[WIN_MAX];
   logic [WIN_BITS-1:0]     window_setting;
   int                      ring_ptr;
   int                      held_count;
   longint                  window_sum;

   int  errors        = 0;
   int  requests_sent = 0;
   int  results_seen  = 0;
   int  writes_done   = 0;
   int  hold_left     = 0;
   bit  calm          = 1'b0;

   running_window_average #(
      .MAX_WINDOW    (MAX_WINDOW_DEF),
      .SAMPLE_BITS   (SAMPLE_BITS_DEF),
      .FRACTION_BITS (FRACTION_BITS_DEF)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_average      (rsp_average),
      .csr_write_enable (csr_write_enable),
      .csr_window_len   (csr_window_len)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Drop pointer, fill count and sum; the ring contents stay as they are.
   function automatic void restart_window_model();
      ring_ptr   = 0;
      held_count = 0;
      window_sum = 0;
   endfunction

   // Push one sample into the shadow window and return the average it yields.
   function automatic logic [AVG_W-1:0] advance_window(input logic signed [SMP_W-1:0] s);
      int     span;
      longint scaled;
      // A zero length behaves as one, anything past the ring size as the ring size.
      span = (window_setting == 0) ? 1 : ((window_setting > WIN_MAX) ? WIN_MAX : window_setting);
      if (ring_ptr >= span) ring_ptr = 0;
      // Retire the oldest sample only once the window is full.
      if (held_count >= span) window_sum -= ring_hist[ring_ptr];
      ring_hist[ring_ptr] = s;
      window_sum += s;
      ring_ptr++;
      if (ring_ptr >= span) ring_ptr = 0;
      if (held_count < span) held_count++;
      // Signed division in SystemVerilog truncates toward zero, as the block does.
      scaled = (window_sum * (longint'(1) << FRACTION_BITS_DEF)) / held_count;
      return scaled[AVG_W-1:0];
   endfunction

   function automatic logic signed [SMP_W-1:0] draw_sample(input sample_mix_type mix,
                                                          input logic signed [SMP_W-1:0] run_val);
      case (mix)
         MIX_FULL:      return SMP_W'($urandom);
         MIX_RAILS:     return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         MIX_NEAR_ZERO: return 16'($urandom_range(0, 31)) - 16'd16;
         default:       return run_val;
      endcase
   endfunction

   // Write the window length while the block is idle and restart the shadow window.
   task automatic set_window(input logic [WIN_BITS-1:0] len);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_window_len   <= len;
      window_setting = len;
      restart_window_model();
      writes_done++;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Hold off until every queued request went in and its average came back.
   // Sample at the falling edge so the rising-edge updates have all landed.
   task automatic drain_pipeline();
      while (sample_queue.size() != 0 || mean_expect.size() != 0 || req_valid)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver: advance to the next sample once the current one is taken,
   // and idle at random unless the calm stretch is on.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            mean_expect.insert(mean_expect.size(), advance_window(req_sample));
            requests_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (sample_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_valid  <= 1'b1;
               req_sample <= sample_queue[0];
               sample_queue.delete(0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each accepted average against the oldest expectation,
   // and drive the stall, including one long hold-off that backs up the block.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (mean_expect.size() == 0) begin
               $error("average: no request outstanding, actual %0d", rsp_average);
               errors++;
            end else begin
               front_mean = mean_expect[0];
               mean_expect.delete(0);
               if (rsp_average !== front_mean) begin
                  $error("average mismatch: expected %0d, actual %0d",
                         $signed(front_mean), rsp_average);
                  errors++;
               end
            end
            results_seen++;
            if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   // Stimulus and phase control.
   initial begin
      int                      win_pick;
      sample_mix_type          mix;
      logic signed [SMP_W-1:0] run_val;
      int                      fixed_wins[6];

      fixed_wins = '{64, 127, 0, 1, 65, 2};
      window_setting = WIN_RESET;
      restart_window_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Default window of 64: rails, zero, small values of both signs.
      sample_queue = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh0000,
                       16'shffff, 16'sh0001, 16'shfffd, 16'sh5555, 16'shaaaa};
      drain_pipeline();

      // Zero length behaves as a window of one.
      set_window(7'd0);
      sample_queue = '{16'sh8000, 16'sh7fff, 16'shffff};
      drain_pipeline();

      // Window of three: negative means that must truncate toward zero.
      set_window(7'd3);
      sample_queue = '{16'shffff, 16'sh0000, 16'sh0000, 16'sh0005};
      drain_pipeline();

      // Length above the ring size behaves as the full ring.
      set_window(7'd127);
      sample_queue = '{16'sh7fff, 16'sh8000, 16'sh0001};
      drain_pipeline();

      for (int ph = 0; ph < PHASES; ph++) begin
         win_pick = (ph < 6) ? fixed_wins[ph] : $urandom_range(0, 127);
         set_window(win_pick[WIN_BITS-1:0]);
         calm = (ph == 7);

         // Full window pinned at each rail to reach both extremes of the sum.
         if (ph == 0) begin
            repeat (70) sample_queue.insert(sample_queue.size(), 16'sh7fff);
            repeat (70) sample_queue.insert(sample_queue.size(), 16'sh8000);
            drain_pipeline();
         end

         for (int b = 0; b < BATCHES; b++) begin
            mix     = sample_mix_type'($urandom_range(0, 3));
            run_val = SMP_W'($urandom);
            repeat (BATCH_LEN) sample_queue.insert(sample_queue.size(),
                                                   draw_sample(mix, run_val));
            // Pause the sender mid-phase until every average is back.
            if (b == 1) drain_pipeline();
         end
         drain_pipeline();
         calm = 1'b0;
      end

      $display("Checked %0d averages from %0d requests over %0d window-length writes,",
               results_seen, requests_sent, writes_done);
      $display("including a %0d-cycle response hold-off and a stall-free phase.", HOLD_CYCLES);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: a healthy run ends far earlier.
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== running_window_average.f =====
sv/rwa_pkg.sv
sv/rwa_ram.sv
sv/rwa_divider.sv
sv/running_window_average.sv
test/tb.sv
